/* sv/sbusfd_pkg.sv */
// sbusfd_pkg: shared constants, state type and command/status structs
// for the sbus frame decoder; depends on nothing
`default_nettype none
package sbusfd_pkg;

    localparam int unsigned FRAME_LEN     = 25;
    localparam int unsigned PAYLOAD_BYTES = FRAME_LEN - 1;
    localparam int unsigned POS_W         = 5;
    localparam int unsigned CHAN_W        = 11;
    localparam int unsigned NUM_CHAN      = 16;
    localparam int unsigned INDEX_W       = 4;
    localparam int unsigned FLAGS_W       = 4;
    localparam int unsigned COUNT_W       = 32;
    localparam int unsigned FIRST_PACKED  = 1;
    localparam int unsigned LAST_PACKED   = 22;
    localparam int unsigned PACKED_BYTES  = LAST_PACKED - FIRST_PACKED + 1;
    localparam int unsigned PACKED_W      = PACKED_BYTES * 8;
    localparam int unsigned FLAGS_BYTE    = 23;

    localparam logic [7:0] START_BYTE    = 8'h0F;
    localparam logic [7:0] END_BYTE      = 8'h00;
    localparam logic [7:0] FLAG_BAD_MASK = 8'hF0;

    localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(PAYLOAD_BYTES);
    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(NUM_CHAN - 1);

    // result status codes
    localparam logic STATUS_CHANNEL   = 1'b0;
    localparam logic STATUS_MALFORMED = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } sbusfd_state_t;

    typedef struct packed {
        logic store;
        logic load_good;
        logic load_bad;
        logic advance;
    } sbusfd_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic frame_ok;
        logic last_result;
    } sbusfd_stat_t;

endpackage
`default_nettype wire

/* sv/sbusfd_byte_if.sv */
// sbusfd_byte_if: valid/ready channel carrying one frame byte per request
// depends on nothing
`default_nettype none
interface sbusfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_begin;

    modport source (output valid, output rx_byte, output frame_begin, input ready);
    modport sink   (input valid, input rx_byte, input frame_begin, output ready);
endinterface
`default_nettype wire

/* sv/sbusfd_result_if.sv */
// sbusfd_result_if: valid/ready channel carrying one decoded result per request
// depends on nothing
`default_nettype none
interface sbusfd_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic [3:0]  frame_flags;
    logic [31:0] frames_count;
    logic [31:0] malformed_count;
    logic        last_of_frame;

    modport source (output valid, output status, output channel_index, output channel_value,
                    output frame_flags, output frames_count, output malformed_count,
                    output last_of_frame, input ready);
    modport sink   (input valid, input status, input channel_index, input channel_value,
                    input frame_flags, input frames_count, input malformed_count,
                    input last_of_frame, output ready);
endinterface
`default_nettype wire

/* sv/sbusfd_ctrl.sv */
// sbusfd_ctrl: controller fsm, sequences byte storage and result emission
// depends on sbusfd_pkg
`default_nettype none
module sbusfd_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire sbusfd_pkg::sbusfd_stat_t stat,
    output sbusfd_pkg::sbusfd_cmd_t     cmd
);

    sbusfd_pkg::sbusfd_state_t state_reg;
    sbusfd_pkg::sbusfd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbusfd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            sbusfd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!stat.frame_end)
                    begin
                        cmd.store = 1'b1;
                    end
                    else
                    begin
                        // frame complete: latch good or bad result
                        cmd.load_good = stat.frame_ok;
                        cmd.load_bad  = !stat.frame_ok;
                        state_next    = sbusfd_pkg::ST_EMIT;
                    end
                end
            end
            sbusfd_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.last_result)
                    begin
                        state_next = sbusfd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = sbusfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/sbusfd_datapath.sv */
// sbusfd_datapath: byte shift line, position count, frame check, channel
// unpacking shift register and frame totals; depends on sbusfd_pkg
`default_nettype none
module sbusfd_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [7:0]                    rx_byte,
    input  wire logic                          frame_begin,
    input  wire sbusfd_pkg::sbusfd_cmd_t       cmd,
    output sbusfd_pkg::sbusfd_stat_t           stat,
    output logic                               status,
    output logic [sbusfd_pkg::INDEX_W-1:0]     channel_index,
    output logic [sbusfd_pkg::CHAN_W-1:0]      channel_value,
    output logic [sbusfd_pkg::FLAGS_W-1:0]     frame_flags,
    output logic [sbusfd_pkg::COUNT_W-1:0]     frames_count,
    output logic [sbusfd_pkg::COUNT_W-1:0]     malformed_count,
    output logic                               last_of_frame
);

    logic [7:0]                        bytes_reg [sbusfd_pkg::PAYLOAD_BYTES];
    logic [sbusfd_pkg::POS_W-1:0]      pos_reg;
    logic [sbusfd_pkg::POS_W-1:0]      pos_next;
    logic [sbusfd_pkg::PACKED_W-1:0]   chan_reg;
    logic [sbusfd_pkg::PACKED_W-1:0]   packed_bytes;
    logic [sbusfd_pkg::INDEX_W-1:0]    index_reg;
    logic [sbusfd_pkg::FLAGS_W-1:0]    flags_reg;
    logic                              status_reg;
    logic [sbusfd_pkg::COUNT_W-1:0]    good_reg;
    logic [sbusfd_pkg::COUNT_W-1:0]    bad_reg;

    // bytes 1..22 as one little-endian bit stream
    always_comb
    begin
        for (int i = 0; i < sbusfd_pkg::PACKED_BYTES; i++)
        begin
            packed_bytes[i*8 +: 8] = bytes_reg[i + sbusfd_pkg::FIRST_PACKED];
        end
    end

    always_comb
    begin
        stat.frame_end   = !frame_begin && (pos_reg == sbusfd_pkg::LAST_POS);
        stat.frame_ok    = (bytes_reg[0] == sbusfd_pkg::START_BYTE)
                        && (rx_byte == sbusfd_pkg::END_BYTE)
                        && ((bytes_reg[sbusfd_pkg::FLAGS_BYTE]
                             & sbusfd_pkg::FLAG_BAD_MASK) == 8'h00);
        stat.last_result = (status_reg == sbusfd_pkg::STATUS_MALFORMED)
                        || (index_reg == sbusfd_pkg::LAST_INDEX);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.store)
        begin
            pos_next = frame_begin ? sbusfd_pkg::POS_W'(1) : pos_reg + 1'b1;
        end
        else if (cmd.load_good || cmd.load_bad)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            good_reg <= '0;
            bad_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cmd.load_good)
            begin
                good_reg <= good_reg + 1'b1;
            end
            if (cmd.load_bad)
            begin
                bad_reg <= bad_reg + 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            // shift line: oldest byte of the last 24 sits at entry 0
            for (int i = 0; i < sbusfd_pkg::PAYLOAD_BYTES - 1; i++)
            begin
                bytes_reg[i] <= bytes_reg[i + 1];
            end
            bytes_reg[sbusfd_pkg::PAYLOAD_BYTES - 1] <= rx_byte;
        end
        if (cmd.load_good)
        begin
            chan_reg   <= packed_bytes;
            index_reg  <= '0;
            flags_reg  <= bytes_reg[sbusfd_pkg::FLAGS_BYTE][sbusfd_pkg::FLAGS_W-1:0];
            status_reg <= sbusfd_pkg::STATUS_CHANNEL;
        end
        else if (cmd.load_bad)
        begin
            chan_reg   <= '0;
            index_reg  <= '0;
            flags_reg  <= '0;
            status_reg <= sbusfd_pkg::STATUS_MALFORMED;
        end
        else if (cmd.advance)
        begin
            chan_reg  <= chan_reg >> sbusfd_pkg::CHAN_W;
            index_reg <= index_reg + 1'b1;
        end
    end

    assign status          = status_reg;
    assign channel_index   = index_reg;
    assign channel_value   = chan_reg[sbusfd_pkg::CHAN_W-1:0];
    assign frame_flags     = flags_reg;
    assign frames_count    = good_reg;
    assign malformed_count = bad_reg;
    assign last_of_frame   = stat.last_result;

endmodule
`default_nettype wire

/* sv/sbus_frame_decoder.sv */
// sbus_frame_decoder: top level, joins controller and datapath to the channels
// depends on sbusfd_pkg, sbusfd_byte_if, sbusfd_result_if, sbusfd_ctrl, sbusfd_datapath
//
// channel  | role  | request carries
// ---------+-------+-----------------------------------------------------------
// bytes    | sink  | rx_byte, frame_begin
// results  | source| status, channel_index, channel_value, frame_flags,
//          |       | frames_count, malformed_count, last_of_frame
//
// bytes 0..23 of a frame are taken while idle and give no result
// the 25th byte is taken while idle, then the controller emits 16 channel
// requests (one per cycle while results.ready is high) or one error request;
// bytes.ready is low from then until the final result request is taken
// rst_n is asynchronous, active low; it clears position, totals and the fsm
// a stall on results holds the current result and its fields stable
`default_nettype none
module sbus_frame_decoder (
    input wire logic   clk,
    input wire logic   rst_n,
    sbusfd_byte_if.sink     bytes,
    sbusfd_result_if.source results
);

    sbusfd_pkg::sbusfd_cmd_t  cmd;
    sbusfd_pkg::sbusfd_stat_t stat;

    // controller: idle/emit sequencing, owns both handshakes
    sbusfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bytes.valid),
        .in_ready  (bytes.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: storage, frame check, unpacking and totals
    sbusfd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_byte         (bytes.rx_byte),
        .frame_begin     (bytes.frame_begin),
        .cmd             (cmd),
        .stat            (stat),
        .status          (results.status),
        .channel_index   (results.channel_index),
        .channel_value   (results.channel_value),
        .frame_flags     (results.frame_flags),
        .frames_count    (results.frames_count),
        .malformed_count (results.malformed_count),
        .last_of_frame   (results.last_of_frame)
    );

endmodule
`default_nettype wire
